FILE: hdl/rctm_pkg.sv
// ---------------------------------------------------------------------------
// rctm_pkg
// shared types and constants for the radio channel trim mapper
// ---------------------------------------------------------------------------
package rctm_pkg;

   localparam int NUM_AXES = 4;
   localparam int NUM_ADCS = 6;

   typedef logic [11:0]       adc_type;
   typedef logic [10:0]       pulse_type;
   typedef logic signed [7:0] trim_type;
   typedef logic [7:0]        buttons_type;
   typedef trim_type          trim_array_type [NUM_AXES];

   // full scale of the converter, used as the mapping divisor
   localparam logic [21:0] ADC_FULL   = 22'd4095;
   localparam logic [9:0]  SPAN       = 10'd1000;
   localparam pulse_type   PULSE_MIN  = 11'd1000;
   localparam pulse_type   PULSE_MAX  = 11'd2000;

   localparam buttons_type BUTTONS_RELEASED = 8'hFF;

endpackage

FILE: hdl/rc_channel_trim_mapper.sv
// ---------------------------------------------------------------------------
// rc_channel_trim_mapper
// frame tick to channel values mapper with button-driven stick trims
// ---------------------------------------------------------------------------
// One request per cycle is accepted while rsp_ready is high, and each request
// gives exactly one response, via the input register and then the response
// register. The trim buttons are edge detected at the moment a request is
// accepted, so the trims move with accepted requests only; the updated trims
// are latched with the samples into the input register. Channel scaling (a
// constant multiply by 1000 and a divide by 4095 done as shift plus one
// correction step), trim addition and clamping sit between the two registers.
// Both registers advance under back pressure from rsp_ready, so a new request
// is taken into an empty input register while a finished response waits.
// ---------------------------------------------------------------------------
module rc_channel_trim_mapper import rctm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_throttle_adc,
   input  logic [11:0] req_yaw_adc,
   input  logic [11:0] req_pitch_adc,
   input  logic [11:0] req_roll_adc,
   input  logic [11:0] req_aux_one_adc,
   input  logic [11:0] req_aux_two_adc,
   input  logic [7:0]  req_trim_buttons,
   input  logic        req_switch_one_level,
   input  logic        req_switch_two_level,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_throttle_pulse,
   output logic [10:0] rsp_yaw_pulse,
   output logic [10:0] rsp_pitch_pulse,
   output logic [10:0] rsp_roll_pulse,
   output logic [10:0] rsp_aux_one_pulse,
   output logic [10:0] rsp_aux_two_pulse,
   output logic [10:0] rsp_switch_one_pulse,
   output logic [10:0] rsp_switch_two_pulse,
   output logic signed [7:0] rsp_throttle_offset,
   output logic signed [7:0] rsp_yaw_offset,
   output logic signed [7:0] rsp_pitch_offset,
   output logic signed [7:0] rsp_roll_offset
);

   // button and trim state
   buttons_type    prev_buttons_ff;
   trim_array_type trims_ff;
   trim_array_type trims_in;
   buttons_type    pressed;

   // input register
   logic           stage_valid_ff;
   adc_type        adc_ff [NUM_ADCS];
   logic           sw_one_ff;
   logic           sw_two_ff;
   trim_array_type stage_trims_ff;

   // response register
   logic           rsp_valid_ff;
   pulse_type      pulse_ff [NUM_ADCS];
   logic           sw_one_rsp_ff;
   logic           sw_two_rsp_ff;
   trim_array_type rsp_trims_ff;

   // datapath between the registers
   pulse_type      scaled [NUM_ADCS];
   pulse_type      pulse_in [NUM_ADCS];
   logic signed [12:0] trimmed [NUM_AXES];

   logic advance_out;
   logic load_stage;
   logic accept;

   // pipeline flow control
   assign advance_out = !rsp_valid_ff || rsp_ready;
   assign load_stage  = !stage_valid_ff || advance_out;
   assign accept      = req_valid && load_stage;
   assign req_ready   = load_stage;

   // falling edge against the stored byte: bit 2k raises trim k, 2k+1 lowers
   always_comb begin
      pressed = ~req_trim_buttons & prev_buttons_ff;
      for (int k = 0; k < NUM_AXES; k++) begin
         case ({pressed[2*k], pressed[2*k+1]})
            2'b10:   trims_in[k] = trims_ff[k] + 8'sd1;
            2'b01:   trims_in[k] = trims_ff[k] - 8'sd1;
            default: trims_in[k] = trims_ff[k];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= BUTTONS_RELEASED;
         for (int k = 0; k < NUM_AXES; k++) begin
            trims_ff[k] <= '0;
         end
      end else if (accept) begin
         prev_buttons_ff <= req_trim_buttons;
         trims_ff        <= trims_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (load_stage) begin
         stage_valid_ff <= req_valid;
      end
      if (accept) begin
         adc_ff[0]      <= req_throttle_adc;
         adc_ff[1]      <= req_yaw_adc;
         adc_ff[2]      <= req_pitch_adc;
         adc_ff[3]      <= req_roll_adc;
         adc_ff[4]      <= req_aux_one_adc;
         adc_ff[5]      <= req_aux_two_adc;
         sw_one_ff      <= req_switch_one_level;
         sw_two_ff      <= req_switch_two_level;
         stage_trims_ff <= trims_in;
      end
   end

   // channel scaling, one unit per sample
   for (genvar g = 0; g < NUM_ADCS; g++) begin : g_scale
      rctm_scale u_scale (
         .sample (adc_ff[g]),
         .pulse  (scaled[g])
      );
   end

   // sticks get trim*4 and a clamp to 1000..2000, aux channels pass through
   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         trimmed[k] = $signed({2'b00, scaled[k]})
                    + $signed({{3{stage_trims_ff[k][7]}}, stage_trims_ff[k], 2'b00});
         if (trimmed[k] < $signed({2'b00, PULSE_MIN})) begin
            pulse_in[k] = PULSE_MIN;
         end else if (trimmed[k] > $signed({2'b00, PULSE_MAX})) begin
            pulse_in[k] = PULSE_MAX;
         end else begin
            pulse_in[k] = trimmed[k][10:0];
         end
      end
      for (int a = NUM_AXES; a < NUM_ADCS; a++) begin
         pulse_in[a] = scaled[a];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance_out) begin
         rsp_valid_ff <= stage_valid_ff;
      end
      if (advance_out && stage_valid_ff) begin
         pulse_ff      <= pulse_in;
         sw_one_rsp_ff <= sw_one_ff;
         sw_two_rsp_ff <= sw_two_ff;
         rsp_trims_ff  <= stage_trims_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_throttle_pulse   = pulse_ff[0];
   assign rsp_yaw_pulse        = pulse_ff[1];
   assign rsp_pitch_pulse      = pulse_ff[2];
   assign rsp_roll_pulse       = pulse_ff[3];
   assign rsp_aux_one_pulse    = pulse_ff[4];
   assign rsp_aux_two_pulse    = pulse_ff[5];
   // switch high reads as the low end
   assign rsp_switch_one_pulse = sw_one_rsp_ff ? PULSE_MIN : PULSE_MAX;
   assign rsp_switch_two_pulse = sw_two_rsp_ff ? PULSE_MIN : PULSE_MAX;
   assign rsp_throttle_offset  = rsp_trims_ff[0];
   assign rsp_yaw_offset       = rsp_trims_ff[1];
   assign rsp_pitch_offset     = rsp_trims_ff[2];
   assign rsp_roll_offset      = rsp_trims_ff[3];

endmodule

FILE: hdl/rctm_scale.sv
// ---------------------------------------------------------------------------
// rctm_scale
// maps a 12-bit sample to 1000..2000 as sample*1000/4095 + 1000, truncated
// ---------------------------------------------------------------------------
module rctm_scale import rctm_pkg::*; (
   input  adc_type   sample,
   output pulse_type pulse
);

   logic [21:0] product;
   logic [9:0]  quot_low;
   logic [21:0] remainder;
   logic [9:0]  quot;

   // x/4096 is never more than one below x/4095 for x < 4095*4096
   always_comb begin
      product   = {10'd0, sample} * {12'd0, SPAN};
      quot_low  = product[21:12];
      remainder = product - {quot_low, 12'd0} + {12'd0, quot_low};
      quot      = (remainder >= ADC_FULL) ? quot_low + 10'd1 : quot_low;
      pulse     = {1'b0, quot} + PULSE_MIN;
   end

endmodule

FILE: hdl/rctm_checker.sv
// ---------------------------------------------------------------------------
// rctm_checker
// port-level checks for the channel trim mapper
// ---------------------------------------------------------------------------
module rctm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_throttle_pulse,
   input logic [10:0] rsp_roll_pulse,
   input logic [10:0] rsp_aux_one_pulse,
   input logic [10:0] rsp_switch_one_pulse,
   input logic [10:0] rsp_switch_two_pulse
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_throttle_pulse))
      else $error("stalled response changed");

   // clamped sticks and aux stay in range
   a_stick_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_throttle_pulse >= 11'd1000 && rsp_throttle_pulse <= 11'd2000
                 && rsp_roll_pulse >= 11'd1000 && rsp_roll_pulse <= 11'd2000
                 && rsp_aux_one_pulse >= 11'd1000 && rsp_aux_one_pulse <= 11'd2000)
      else $error("channel value out of range");

   // switches give one of the two end points
   a_switch_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_switch_one_pulse == 11'd1000 || rsp_switch_one_pulse == 11'd2000)
                 && (rsp_switch_two_pulse == 11'd1000 || rsp_switch_two_pulse == 11'd2000))
      else $error("switch value not an end point");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rc_channel_trim_mapper rctm_checker u_rctm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_throttle_pulse   (rsp_throttle_pulse),
   .rsp_roll_pulse       (rsp_roll_pulse),
   .rsp_aux_one_pulse    (rsp_aux_one_pulse),
   .rsp_switch_one_pulse (rsp_switch_one_pulse),
   .rsp_switch_two_pulse (rsp_switch_two_pulse)
);

FILE: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench for rc_channel_trim_mapper
// drives frame ticks through the request channel and checks each response
// against a cycle-free model of the trim edge logic and channel mapping
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rctm_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WRAP_RUN_FRAMES = 280;
   localparam int MIXED_FRAMES    = 140;

   // idling per phase: no idling, sender idle, receiver stalling, both
   localparam int SENDER_IDLE [4]    = '{0, 76, 0, 16};
   localparam int RECEIVER_STALL [4] = '{0, 0, 76, 16};

   // button bytes of the directed part: edges, holds, both-of-a-pair and
   // every single button in turn
   localparam buttons_type DIRECTED_BUTTONS [24] = '{
      8'hFF, 8'hFF, 8'hAA, 8'hFF, 8'h55, 8'h55, 8'hFF, 8'h00,
      8'h00, 8'hFF, 8'h55, 8'hFF, 8'h55, 8'hFE, 8'hFD, 8'hFB,
      8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h0F, 8'hF0, 8'hFF};

   // one frame tick as sent: throttle, yaw, pitch, roll, aux one, aux two
   typedef struct packed {
      adc_type [NUM_ADCS-1:0] adc;
      buttons_type            buttons;
      logic                   switch_one;
      logic                   switch_two;
   } frame_request_type;

   // channel values in output order, then the four trims
   typedef struct packed {
      pulse_type [7:0]          pulse;
      logic [NUM_AXES-1:0][7:0] trim;
   } frame_result_type;

   // tracks trims and button history of accepted requests and holds the
   // channel frames still owed by the block
   class channel_frame_checker;
      trim_type         axis_trim [NUM_AXES];
      buttons_type      held_buttons;
      frame_result_type expected_frames [$];
      int               mismatches;
      string            pulse_names [8] = '{"throttle", "yaw", "pitch", "roll",
                                            "aux_one", "aux_two", "switch_one",
                                            "switch_two"};
      string            trim_names [NUM_AXES] = '{"throttle_offset", "yaw_offset",
                                                  "pitch_offset", "roll_offset"};

      function new();
         held_buttons = BUTTONS_RELEASED;
         foreach (axis_trim[k]) axis_trim[k] = '0;
         mismatches = 0;
      endfunction

      function pulse_type scaled(adc_type raw);
         int unsigned s;
         s = 32'(raw);
         return pulse_type'(s * SPAN / ADC_FULL + PULSE_MIN);
      endfunction

      function pulse_type trimmed(adc_type raw, trim_type t);
         int v;
         v = int'(scaled(raw)) + int'(t) * 4;
         if (v < int'(PULSE_MIN)) v = int'(PULSE_MIN);
         if (v > int'(PULSE_MAX)) v = int'(PULSE_MAX);
         return pulse_type'(v);
      endfunction

      function void note_request(frame_request_type r);
         buttons_type      fresh;
         frame_result_type e;
         // falling edges only: pressed now, released last frame
         fresh = ~r.buttons & held_buttons;
         for (int i = 0; i < 8; i++) begin
            if (fresh[i]) begin
               if (i % 2 == 1) axis_trim[i/2] = axis_trim[i/2] - trim_type'(1);
               else axis_trim[i/2] = axis_trim[i/2] + trim_type'(1);
            end
         end
         held_buttons = r.buttons;
         for (int k = 0; k < NUM_AXES; k++) begin
            e.pulse[k] = trimmed(r.adc[k], axis_trim[k]);
            e.trim[k]  = axis_trim[k];
         end
         e.pulse[4] = scaled(r.adc[4]);
         e.pulse[5] = scaled(r.adc[5]);
         e.pulse[6] = r.switch_one ? PULSE_MIN : PULSE_MAX;
         e.pulse[7] = r.switch_two ? PULSE_MIN : PULSE_MAX;
         expected_frames.push_back(e);
      endfunction

      function void report(string what, logic signed [15:0] want,
                           logic signed [15:0] seen);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, seen);
      endfunction

      function void check_response(frame_result_type got);
         frame_result_type e;
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with no request outstanding");
            return;
         end
         e = expected_frames.pop_front();
         for (int c = 0; c < 8; c++)
            if (got.pulse[c] !== e.pulse[c])
               report(pulse_names[c], e.pulse[c], got.pulse[c]);
         for (int k = 0; k < NUM_AXES; k++)
            if (got.trim[k] !== e.trim[k])
               report(trim_names[k], $signed(e.trim[k]), $signed(got.trim[k]));
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, all known from time zero
   logic        req_valid            = 1'b0;
   logic        req_ready;
   adc_type     req_throttle_adc     = '0;
   adc_type     req_yaw_adc          = '0;
   adc_type     req_pitch_adc        = '0;
   adc_type     req_roll_adc         = '0;
   adc_type     req_aux_one_adc      = '0;
   adc_type     req_aux_two_adc      = '0;
   buttons_type req_trim_buttons     = BUTTONS_RELEASED;
   logic        req_switch_one_level = 1'b0;
   logic        req_switch_two_level = 1'b0;

   // response channel
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pulse_type         rsp_throttle_pulse;
   pulse_type         rsp_yaw_pulse;
   pulse_type         rsp_pitch_pulse;
   pulse_type         rsp_roll_pulse;
   pulse_type         rsp_aux_one_pulse;
   pulse_type         rsp_aux_two_pulse;
   pulse_type         rsp_switch_one_pulse;
   pulse_type         rsp_switch_two_pulse;
   logic signed [7:0] rsp_throttle_offset;
   logic signed [7:0] rsp_yaw_offset;
   logic signed [7:0] rsp_pitch_offset;
   logic signed [7:0] rsp_roll_offset;

   // pacing knobs; the receiver knob is only written with nonblocking
   // assignments since the receiver process reads it at the same edge
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_orders    = 0;
   int hold_off_served    = 0;
   int stall_left         = 0;
   int cycle_count        = 0;

   // last button byte handed to the block, for well-formed press sequences
   buttons_type sent_buttons = BUTTONS_RELEASED;

   channel_frame_checker frame_checker = new();

   rc_channel_trim_mapper uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_throttle_adc     (req_throttle_adc),
      .req_yaw_adc          (req_yaw_adc),
      .req_pitch_adc        (req_pitch_adc),
      .req_roll_adc         (req_roll_adc),
      .req_aux_one_adc      (req_aux_one_adc),
      .req_aux_two_adc      (req_aux_two_adc),
      .req_trim_buttons     (req_trim_buttons),
      .req_switch_one_level (req_switch_one_level),
      .req_switch_two_level (req_switch_two_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_throttle_pulse   (rsp_throttle_pulse),
      .rsp_yaw_pulse        (rsp_yaw_pulse),
      .rsp_pitch_pulse      (rsp_pitch_pulse),
      .rsp_roll_pulse       (rsp_roll_pulse),
      .rsp_aux_one_pulse    (rsp_aux_one_pulse),
      .rsp_aux_two_pulse    (rsp_aux_two_pulse),
      .rsp_switch_one_pulse (rsp_switch_one_pulse),
      .rsp_switch_two_pulse (rsp_switch_two_pulse),
      .rsp_throttle_offset  (rsp_throttle_offset),
      .rsp_yaw_offset       (rsp_yaw_offset),
      .rsp_pitch_offset     (rsp_pitch_offset),
      .rsp_roll_offset      (rsp_roll_offset)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: check what is taken at this edge, then pick next ready;
   // a hold-off order from the stimulus holds ready low for a long stretch
   always @(posedge clock) begin
      frame_result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.pulse[0] = rsp_throttle_pulse;
         seen.pulse[1] = rsp_yaw_pulse;
         seen.pulse[2] = rsp_pitch_pulse;
         seen.pulse[3] = rsp_roll_pulse;
         seen.pulse[4] = rsp_aux_one_pulse;
         seen.pulse[5] = rsp_aux_two_pulse;
         seen.pulse[6] = rsp_switch_one_pulse;
         seen.pulse[7] = rsp_switch_two_pulse;
         seen.trim[0]  = rsp_throttle_offset;
         seen.trim[1]  = rsp_yaw_offset;
         seen.trim[2]  = rsp_pitch_offset;
         seen.trim[3]  = rsp_roll_offset;
         frame_checker.check_response(seen);
      end
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (hold_off_orders != hold_off_served) begin
         hold_off_served <= hold_off_orders;
         stall_left      <= HOLD_OFF_CYCLES - 1;
         rsp_ready       <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // offer one request, with random idle cycles ahead of it, and return at
   // the edge where it is taken
   task automatic send_frame(input frame_request_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_throttle_adc     <= r.adc[0];
      req_yaw_adc          <= r.adc[1];
      req_pitch_adc        <= r.adc[2];
      req_roll_adc         <= r.adc[3];
      req_aux_one_adc      <= r.adc[4];
      req_aux_two_adc      <= r.adc[5];
      req_trim_buttons     <= r.buttons;
      req_switch_one_level <= r.switch_one;
      req_switch_two_level <= r.switch_two;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frame_checker.note_request(r);
      sent_buttons = r.buttons;
   endtask

   // samples lean on the ends of the range where mapping and clamping bite
   function automatic adc_type pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return adc_type'(4095);
         2:       return adc_type'($urandom_range(15));
         3:       return adc_type'(4095 - $urandom_range(15));
         default: return adc_type'($urandom_range(4095));
      endcase
   endfunction

   function automatic frame_request_type random_frame(buttons_type b);
      frame_request_type r;
      for (int c = 0; c < NUM_ADCS; c++) r.adc[c] = pick_sample();
      r.buttons    = b;
      r.switch_one = 1'($urandom_range(1));
      r.switch_two = 1'($urandom_range(1));
      return r;
   endfunction

   // noise, single press then release, holds, and both buttons of a pair
   function automatic buttons_type mixed_buttons(buttons_type last);
      int k;
      k = $urandom_range(NUM_AXES - 1);
      case ($urandom_range(9))
         0, 1, 2, 3: return buttons_type'($urandom_range(255));
         4, 5, 6: begin
            if (last != BUTTONS_RELEASED) return BUTTONS_RELEASED;
            return ~(buttons_type'(1) << $urandom_range(7));
         end
         7, 8:    return last;
         default: return ~(buttons_type'(3) << (2 * k));
      endcase
   endfunction

   initial begin
      frame_request_type r;
      int                axis;
      int                press_bit;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part: all-low and all-high samples, mid-scale patterns and
      // every switch combination under the button sequence above
      foreach (DIRECTED_BUTTONS[n]) begin
         r = random_frame(DIRECTED_BUTTONS[n]);
         case (n % 4)
            0: r.adc = '0;
            1: r.adc = '1;
            2: r.adc = {12'h800, 12'h001, 12'hFFE, 12'h7FF, 12'h555, 12'hAAA};
            default: ;
         endcase
         r.switch_one = n[0];
         r.switch_two = n[1];
         send_frame(r);
      end

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct     = SENDER_IDLE[phase];
         receiver_stall_pct <= RECEIVER_STALL[phase];

         // long receiver hold-off while requests keep coming, so the block
         // fills up and drops req_ready
         if (phase == 0 || phase == 3) hold_off_orders <= hold_off_orders + 1;

         // press-release train on one axis, heading away from zero, long
         // enough to wrap the trim and saturate the stick channel
         axis      = $urandom_range(NUM_AXES - 1);
         press_bit = 2 * axis + ((frame_checker.axis_trim[axis] < 0) ? 1 : 0);
         for (int j = 0; j < WRAP_RUN_FRAMES; j++) begin
            if (j % 2 == 1) send_frame(random_frame(BUTTONS_RELEASED));
            else send_frame(random_frame(~(buttons_type'(1) << press_bit)));
         end

         for (int j = 0; j < MIXED_FRAMES; j++)
            send_frame(random_frame(mixed_buttons(sent_buttons)));
      end
      req_valid <= 1'b0;

      // drain, then a few more cycles to catch anything extra
      while (frame_checker.expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (frame_checker.mismatches == 0 && frame_checker.expected_frames.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/rctm_pkg.sv
hdl/rctm_scale.sv
hdl/rc_channel_trim_mapper.sv
hdl/rctm_checker.sv
tb/testbench.sv
